@@ rtl/dc2d_pkg.sv @@
// Shared types and constants for the direct 2-D convolution engine.
package dc2d_pkg;

  localparam int INPUT_WORDS_DEF  = 16384;
  localparam int WEIGHT_WORDS_DEF = 4096;

  localparam logic [1:0] OP_LOAD_IN  = 2'd0;
  localparam logic [1:0] OP_LOAD_WT  = 2'd1;
  localparam logic [1:0] OP_COMPUTE  = 2'd2;

  localparam logic [2:0] REG_IN_HEIGHT   = 3'd0;
  localparam logic [2:0] REG_IN_WIDTH    = 3'd1;
  localparam logic [2:0] REG_KERN_HEIGHT = 3'd2;
  localparam logic [2:0] REG_KERN_WIDTH  = 3'd3;
  localparam logic [2:0] REG_STRIDE_H    = 3'd4;
  localparam logic [2:0] REG_STRIDE_W    = 3'd5;
  localparam logic [2:0] REG_IN_CHANNELS = 3'd6;
  localparam logic [2:0] REG_OUT_CHANNELS = 3'd7;

  localparam int CFG_DATA_W = 11;
  localparam int IA_W       = 35;
  localparam int WA_W       = 33;
  localparam int WIN_W      = 77;
  localparam int SUM_W      = 78;

  localparam logic [31:0] FP_DEFAULT_NAN = 32'hFFC0_0000;
  localparam logic [31:0] FP_QUIET_BIT   = 32'h0040_0000;

  typedef enum logic [1:0] {ADV_NONE, ADV_C, ADV_S, ADV_R} adv_e;

  typedef struct packed {
    logic [10:0] in_height;
    logic [10:0] in_width;
    logic [4:0]  kern_height;
    logic [4:0]  kern_width;
    logic [4:0]  stride_height;
    logic [4:0]  stride_width;
    logic [10:0] in_channels;
    logic [10:0] out_channels;
  } cfg_t;

  typedef struct packed {
    logic setup1;
    logic setup2;
    logic read;
    logic acc_load;
    adv_e adv;
    logic res_load;
    logic res_err;
  } cmd_t;

  typedef struct packed {
    logic err;
    logic empty;
  } sts_t;

endpackage

@@ rtl/dc2d_if.sv @@
// Item channel interfaces: input items and result items.
interface dc2d_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [13:0] address;
  logic [31:0] data;
  logic [9:0]  out_channel;
  logic [9:0]  out_row;
  logic [9:0]  out_col;

  modport source (output valid, operation, address, data, out_channel, out_row, out_col,
                  input ready);
  modport sink (input valid, operation, address, data, out_channel, out_row, out_col,
                output ready);
endinterface

interface dc2d_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] result_value;
  logic        error;

  modport source (output valid, result_value, error, input ready);
  modport sink (input valid, result_value, error, output ready);
endinterface

@@ rtl/dc2d_cfg.sv @@
// Configuration register file.
module dc2d_cfg (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [2:0]                         cfg_index_i,
  input  logic [dc2d_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  output dc2d_pkg::cfg_t                     cfg_o
);
  import dc2d_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.in_height     <= 11'd1;
      cfg_q.in_width      <= 11'd1;
      cfg_q.kern_height   <= 5'd1;
      cfg_q.kern_width    <= 5'd1;
      cfg_q.stride_height <= 5'd1;
      cfg_q.stride_width  <= 5'd1;
      cfg_q.in_channels   <= 11'd1;
      cfg_q.out_channels  <= 11'd1;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_IN_HEIGHT:    cfg_q.in_height     <= cfg_data_i;
        REG_IN_WIDTH:     cfg_q.in_width      <= cfg_data_i;
        REG_KERN_HEIGHT:  cfg_q.kern_height   <= cfg_data_i[4:0];
        REG_KERN_WIDTH:   cfg_q.kern_width    <= cfg_data_i[4:0];
        REG_STRIDE_H:     cfg_q.stride_height <= cfg_data_i[4:0];
        REG_STRIDE_W:     cfg_q.stride_width  <= cfg_data_i[4:0];
        REG_IN_CHANNELS:  cfg_q.in_channels   <= cfg_data_i;
        REG_OUT_CHANNELS: cfg_q.out_channels  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ rtl/dc2d_ctrl.sv @@
// Sequencer: setup, kernel loop over r, s, c and the multi-cycle FMA steps.
module dc2d_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  dc2d_pkg::cfg_t  cfg_i,
  input  logic            take_compute_i,
  input  logic            out_ready_i,
  input  dc2d_pkg::sts_t  sts_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  output dc2d_pkg::cmd_t  cmd_o
);
  import dc2d_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SETUP1, ST_SETUP2, ST_CHECK, ST_READ, ST_MUL, ST_ALIGN,
    ST_ADD, ST_LZC, ST_SHIFT, ST_ROUND, ST_FINISH
  } state_e;

  state_e      state_q;
  logic [4:0]  r_q, s_q;
  logic [10:0] c_q;
  logic        out_valid_q;
  logic        err_q;
  logic        last_c, last_s, last_r;
  logic        res_fire;

  assign last_c   = c_q == cfg_i.in_channels - 11'd1;
  assign last_s   = s_q == cfg_i.kern_width - 5'd1;
  assign last_r   = r_q == cfg_i.kern_height - 5'd1;
  assign res_fire = (state_q == ST_FINISH) && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      r_q         <= '0;
      s_q         <= '0;
      c_q         <= '0;
      out_valid_q <= 1'b0;
      err_q       <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (take_compute_i) begin
            state_q <= ST_SETUP1;
          end
        end
        ST_SETUP1: state_q <= ST_SETUP2;
        ST_SETUP2: state_q <= ST_CHECK;
        ST_CHECK: begin
          err_q <= sts_i.err;
          r_q   <= '0;
          s_q   <= '0;
          c_q   <= '0;
          if (sts_i.err || sts_i.empty) begin
            state_q <= ST_FINISH;
          end else begin
            state_q <= ST_READ;
          end
        end
        ST_READ:  state_q <= ST_MUL;
        ST_MUL:   state_q <= ST_ALIGN;
        ST_ALIGN: state_q <= ST_ADD;
        ST_ADD:   state_q <= ST_LZC;
        ST_LZC:   state_q <= ST_SHIFT;
        ST_SHIFT: state_q <= ST_ROUND;
        ST_ROUND: begin
          if (!last_c) begin
            c_q     <= c_q + 11'd1;
            state_q <= ST_READ;
          end else if (!last_s) begin
            c_q     <= '0;
            s_q     <= s_q + 5'd1;
            state_q <= ST_READ;
          end else if (!last_r) begin
            c_q     <= '0;
            s_q     <= '0;
            r_q     <= r_q + 5'd1;
            state_q <= ST_READ;
          end else begin
            state_q <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (res_fire) begin
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.adv      = ADV_NONE;
    case (state_q)
      ST_SETUP1: cmd_o.setup1 = 1'b1;
      ST_SETUP2: cmd_o.setup2 = 1'b1;
      ST_READ:   cmd_o.read   = 1'b1;
      ST_ROUND: begin
        cmd_o.acc_load = 1'b1;
        if (!last_c) begin
          cmd_o.adv = ADV_C;
        end else if (!last_s) begin
          cmd_o.adv = ADV_S;
        end else if (!last_r) begin
          cmd_o.adv = ADV_R;
        end else begin
          cmd_o.adv = ADV_NONE;
        end
      end
      ST_FINISH: begin
        cmd_o.res_load = res_fire;
        cmd_o.res_err  = err_q;
      end
      default: ;
    endcase
  end

  assign in_ready_o  = state_q == ST_IDLE;
  assign out_valid_o = out_valid_q;

endmodule

@@ rtl/dc2d_dp.sv @@
// Datapath: stores, address walkers, bounds check and the staged fp32 FMA.
module dc2d_dp #(
  parameter int INPUT_WORDS  = dc2d_pkg::INPUT_WORDS_DEF,
  parameter int WEIGHT_WORDS = dc2d_pkg::WEIGHT_WORDS_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  dc2d_pkg::cfg_t  cfg_i,
  input  dc2d_pkg::cmd_t  cmd_i,
  input  logic            take_i,
  input  logic [1:0]      operation_i,
  input  logic [13:0]     address_i,
  input  logic [31:0]     data_i,
  input  logic [9:0]      out_channel_i,
  input  logic [9:0]      out_row_i,
  input  logic [9:0]      out_col_i,
  output dc2d_pkg::sts_t  sts_o,
  output logic [31:0]     result_value_o,
  output logic            error_o
);
  import dc2d_pkg::*;

  localparam int IAW = $clog2(INPUT_WORDS);
  localparam int WAW = $clog2(WEIGHT_WORDS);

  logic [31:0] imem [INPUT_WORDS];
  logic [31:0] wmem [WEIGHT_WORDS];

  // target and setup products
  logic [9:0]  k_q, y_q, x_q;
  logic [4:0]  sh_eff, sw_eff;
  logic [14:0] ysh_q, xsw_q;
  logic [20:0] kic_q;
  logic [21:0] plane_q;
  logic [9:0]  kk_q;
  sts_t        sts_q;

  // address walkers
  logic [IA_W-1:0] ia_cur_q, ia_s_q, ia_r_q;
  logic [WA_W-1:0] wa_cur_q, wa_s_q, wa_r_q;

  // read stage
  logic [31:0] in_rd_q, wt_rd_q;
  logic        in_ok_q, wt_ok_q;

  // FMA stages
  logic [31:0] acc_q;
  logic [47:0] mp_q;
  logic [8:0]  se_q;
  logic        sp_q, sc_q;
  logic [23:0] mc_q;
  logic [7:0]  ec_q;
  logic        spec_q;
  logic [31:0] spec_val_q;
  logic [WIN_W-1:0] p_q, a_q;
  logic signed [11:0] l_q;
  logic [SUM_W-1:0] m_q;
  logic        ms_q;
  logic [6:0]  pos_q;
  logic        mz_q;
  logic [23:0] rm_q;
  logic        g_q, st_q;
  logic [9:0]  ef_q;

  logic [31:0] res_value_q;
  logic        res_err_q;

  assign sh_eff = (cfg_i.stride_height == 5'd0) ? 5'd1 : cfg_i.stride_height;
  assign sw_eff = (cfg_i.stride_width == 5'd0) ? 5'd1 : cfg_i.stride_width;

  // stores
  always_ff @(posedge clk_i) begin
    if (take_i && operation_i == OP_LOAD_IN && 32'(address_i) < 32'(INPUT_WORDS)) begin
      imem[IAW'(address_i)] <= data_i;
    end
    if (take_i && operation_i == OP_LOAD_WT && 32'(address_i) < 32'(WEIGHT_WORDS)) begin
      wmem[WAW'(address_i)] <= data_i;
    end
    if (cmd_i.read) begin
      in_rd_q <= imem[ia_cur_q[IAW-1:0]];
      wt_rd_q <= wmem[wa_cur_q[WAW-1:0]];
      in_ok_q <= ia_cur_q < IA_W'(INPUT_WORDS);
      wt_ok_q <= wa_cur_q < WA_W'(WEIGHT_WORDS);
    end
  end

  // setup and address walk
  logic [25:0] ibase_w;
  logic [30:0] wbase_w;
  logic        row_ok, col_ok;

  assign ibase_w = {11'b0, ysh_q} * {15'b0, cfg_i.in_width} + {11'b0, xsw_q};
  assign wbase_w = {10'b0, kic_q} * {21'b0, kk_q};
  assign row_ok  = (cfg_i.in_height >= 11'(cfg_i.kern_height)) &&
                   (ysh_q <= 15'(cfg_i.in_height - 11'(cfg_i.kern_height)));
  assign col_ok  = (cfg_i.in_width >= 11'(cfg_i.kern_width)) &&
                   (xsw_q <= 15'(cfg_i.in_width - 11'(cfg_i.kern_width)));

  always_ff @(posedge clk_i) begin
    if (take_i) begin
      k_q <= out_channel_i;
      y_q <= out_row_i;
      x_q <= out_col_i;
    end
    if (cmd_i.setup1) begin
      ysh_q   <= {5'b0, y_q} * {10'b0, sh_eff};
      xsw_q   <= {5'b0, x_q} * {10'b0, sw_eff};
      kic_q   <= {11'b0, k_q} * {10'b0, cfg_i.in_channels};
      plane_q <= {11'b0, cfg_i.in_height} * {11'b0, cfg_i.in_width};
      kk_q    <= {5'b0, cfg_i.kern_height} * {5'b0, cfg_i.kern_width};
    end
    if (cmd_i.setup2) begin
      ia_cur_q <= IA_W'(ibase_w);
      ia_s_q   <= IA_W'(ibase_w);
      ia_r_q   <= IA_W'(ibase_w);
      wa_cur_q <= WA_W'(wbase_w);
      wa_s_q   <= WA_W'(wbase_w);
      wa_r_q   <= WA_W'(wbase_w);
    end else begin
      case (cmd_i.adv)
        ADV_C: begin
          ia_cur_q <= ia_cur_q + IA_W'(plane_q);
          wa_cur_q <= wa_cur_q + WA_W'(kk_q);
        end
        ADV_S: begin
          ia_cur_q <= ia_s_q + IA_W'(1);
          ia_s_q   <= ia_s_q + IA_W'(1);
          wa_cur_q <= wa_s_q + WA_W'(1);
          wa_s_q   <= wa_s_q + WA_W'(1);
        end
        ADV_R: begin
          ia_cur_q <= ia_r_q + IA_W'(cfg_i.in_width);
          ia_s_q   <= ia_r_q + IA_W'(cfg_i.in_width);
          ia_r_q   <= ia_r_q + IA_W'(cfg_i.in_width);
          wa_cur_q <= wa_r_q + WA_W'(cfg_i.kern_width);
          wa_s_q   <= wa_r_q + WA_W'(cfg_i.kern_width);
          wa_r_q   <= wa_r_q + WA_W'(cfg_i.kern_width);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sts_q <= '0;
    end else if (cmd_i.setup2) begin
      sts_q.err   <= ({1'b0, k_q} >= cfg_i.out_channels) || !row_ok || !col_ok;
      sts_q.empty <= (cfg_i.kern_height == 5'd0) || (cfg_i.kern_width == 5'd0) ||
                     (cfg_i.in_channels == 11'd0);
    end
  end

  assign sts_o = sts_q;

  // FMA multiply stage: unpack, mantissa product, special operands
  logic [31:0] fa, fb, fc;
  logic [7:0]  ea, eb, ec;
  logic        a_nan, b_nan, c_nan, a_inf, b_inf, c_inf, a_zero, b_zero, c_zero;
  logic        sp_w;
  logic        spec_w;
  logic [31:0] spec_val_w;

  assign fa = in_ok_q ? in_rd_q : 32'd0;
  assign fb = wt_ok_q ? wt_rd_q : 32'd0;
  assign fc = acc_q;
  assign ea = (fa[30:23] == 8'd0) ? 8'd1 : fa[30:23];
  assign eb = (fb[30:23] == 8'd0) ? 8'd1 : fb[30:23];
  assign ec = (fc[30:23] == 8'd0) ? 8'd1 : fc[30:23];
  assign a_nan  = (fa[30:23] == 8'hFF) && (fa[22:0] != 23'd0);
  assign b_nan  = (fb[30:23] == 8'hFF) && (fb[22:0] != 23'd0);
  assign c_nan  = (fc[30:23] == 8'hFF) && (fc[22:0] != 23'd0);
  assign a_inf  = (fa[30:23] == 8'hFF) && (fa[22:0] == 23'd0);
  assign b_inf  = (fb[30:23] == 8'hFF) && (fb[22:0] == 23'd0);
  assign c_inf  = (fc[30:23] == 8'hFF) && (fc[22:0] == 23'd0);
  assign a_zero = fa[30:0] == 31'd0;
  assign b_zero = fb[30:0] == 31'd0;
  assign c_zero = fc[30:0] == 31'd0;
  assign sp_w   = fa[31] ^ fb[31];

  always_comb begin
    spec_w     = 1'b1;
    spec_val_w = fc;
    if (a_nan) begin
      spec_val_w = fa | FP_QUIET_BIT;
    end else if (b_nan) begin
      spec_val_w = fb | FP_QUIET_BIT;
    end else if ((a_inf && b_zero) || (b_inf && a_zero)) begin
      spec_val_w = FP_DEFAULT_NAN;
    end else if (c_nan) begin
      spec_val_w = fc | FP_QUIET_BIT;
    end else if (a_inf || b_inf) begin
      if (c_inf && (fc[31] != sp_w)) begin
        spec_val_w = FP_DEFAULT_NAN;
      end else begin
        spec_val_w = {sp_w, 31'h7F80_0000};
      end
    end else if (c_inf) begin
      spec_val_w = fc;
    end else if (a_zero || b_zero) begin
      if (c_zero) begin
        spec_val_w = {sp_w & fc[31], 31'd0};
      end else begin
        spec_val_w = fc;
      end
    end else begin
      spec_w = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    mp_q       <= {fa[30:23] != 8'd0, fa[22:0]} * {fb[30:23] != 8'd0, fb[22:0]};
    se_q       <= {1'b0, ea} + {1'b0, eb};
    sp_q       <= sp_w;
    mc_q       <= {fc[30:23] != 8'd0, fc[22:0]};
    ec_q       <= ec;
    sc_q       <= fc[31];
    spec_q     <= spec_w;
    spec_val_q <= spec_val_w;
  end

  // align stage: product at bits 50..3, addend moved relative to it
  logic signed [11:0] sh_w;
  logic [6:0]         shamt;
  logic [161:0]       aext;
  logic [WIN_W-1:0]   p_d, a_d;
  logic signed [11:0] l_d;

  assign sh_w = $signed({3'b0, se_q}) - $signed({4'b0, ec_q}) - 12'sd100;

  always_comb begin
    shamt = (sh_w > 12'sd85) ? 7'd85 : sh_w[6:0];
    aext  = {mc_q, 53'b0, 85'b0} >> shamt;
    if (sh_w[11]) begin
      p_d = {76'b0, |mp_q};
      a_d = {mc_q, 53'b0};
      l_d = $signed({4'b0, ec_q}) - 12'sd203;
    end else begin
      p_d = {26'b0, mp_q, 3'b0};
      a_d = aext[161:85] | {76'b0, |aext[84:0]};
      l_d = $signed({3'b0, se_q}) - 12'sd303;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
    a_q <= a_d;
    l_q <= l_d;
  end

  // add stage
  logic             p_ge_a;
  logic [SUM_W-1:0] m_d;
  logic             ms_d;

  assign p_ge_a = p_q >= a_q;

  always_comb begin
    if (sp_q == sc_q) begin
      m_d  = {1'b0, p_q} + {1'b0, a_q};
      ms_d = sp_q;
    end else if (p_ge_a) begin
      m_d  = {1'b0, p_q - a_q};
      ms_d = sp_q;
    end else begin
      m_d  = {1'b0, a_q - p_q};
      ms_d = sc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    m_q  <= m_d;
    ms_q <= ms_d;
  end

  // leading one
  logic [6:0] pos_d;

  always_comb begin
    pos_d = '0;
    for (int i = 0; i < SUM_W; i++) begin
      if (m_q[i]) begin
        pos_d = 7'(i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
    mz_q  <= m_q == '0;
  end

  // shift to the rounding position (normal or subnormal)
  logic signed [11:0] lo_w, t_w, q_w, ef_w, nq_w;
  logic               norm;
  logic [6:0]         qa;
  logic [167:0]       rext;
  logic [SUM_W-1:0]   lsh;
  logic [23:0]        rm_d;
  logic               g_d, st_d;

  assign lo_w = -12'sd149 - l_q;
  assign t_w  = $signed({5'b0, pos_q}) - 12'sd23;
  assign ef_w = $signed({5'b0, pos_q}) + l_q + 12'sd126;
  assign norm = t_w >= lo_w;
  assign q_w  = norm ? t_w : lo_w;
  assign nq_w = -q_w;

  always_comb begin
    qa   = (q_w > 12'sd90) ? 7'd90 : q_w[6:0];
    rext = {m_q, 90'b0} >> qa;
    lsh  = m_q << nq_w[4:0];
    if (q_w > 12'sd0) begin
      rm_d = rext[113:90];
      g_d  = rext[89];
      st_d = |rext[88:0];
    end else begin
      rm_d = lsh[23:0];
      g_d  = 1'b0;
      st_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    rm_q <= rm_d;
    g_q  <= g_d;
    st_q <= st_d;
    ef_q <= norm ? ef_w[9:0] : 10'd0;
  end

  // round to nearest even and pack
  logic        inc;
  logic [24:0] rr;
  logic [32:0] packed_w;
  logic [31:0] fma_w;

  assign inc      = g_q & (st_q | rm_q[0]);
  assign rr       = {1'b0, rm_q} + {24'b0, inc};
  assign packed_w = {ef_q, 23'b0} + {8'b0, rr};

  always_comb begin
    if (spec_q) begin
      fma_w = spec_val_q;
    end else if (mz_q) begin
      fma_w = 32'd0;
    end else if (packed_w >= 33'h0_7F80_0000) begin
      fma_w = {ms_q, 31'h7F80_0000};
    end else begin
      fma_w = {ms_q, packed_w[30:0]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.setup1) begin
      acc_q <= 32'd0;
    end else if (cmd_i.acc_load) begin
      acc_q <= fma_w;
    end
    if (cmd_i.res_load) begin
      res_value_q <= cmd_i.res_err ? 32'd0 : acc_q;
      res_err_q   <= cmd_i.res_err;
    end
  end

  assign result_value_o = res_value_q;
  assign error_o        = res_err_q;

endmodule

@@ rtl/direct_conv2d_forward.sv @@
// Top level of the direct fp32 2-D convolution engine.
// Load items give no result. With N = in_channels * kern_height * kern_width, a
// compute item runs setup and a check, then a read and FMA pass (read, multiply,
// align, add, leading one, shift, round) for each of its N multiply-adds; error
// and empty-sum results skip them. No item is taken while one computes. Reset
// idles control and sets config fields to 1; stores hold nothing until loaded.
module direct_conv2d_forward #(
  parameter int INPUT_WORDS  = dc2d_pkg::INPUT_WORDS_DEF,
  parameter int WEIGHT_WORDS = dc2d_pkg::WEIGHT_WORDS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  dc2d_in_if.sink                          in_i,
  dc2d_out_if.source                       out_o,
  input  logic                             cfg_we_i,
  input  logic [2:0]                       cfg_index_i,
  input  logic [dc2d_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import dc2d_pkg::*;

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;
  logic take, take_compute, in_ready;

  assign take         = in_i.valid && in_ready;
  assign take_compute = take && (in_i.operation == OP_COMPUTE);
  assign in_i.ready   = in_ready;

  dc2d_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  dc2d_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .take_compute_i (take_compute),
    .out_ready_i    (out_o.ready),
    .sts_i          (sts),
    .in_ready_o     (in_ready),
    .out_valid_o    (out_o.valid),
    .cmd_o          (cmd)
  );

  dc2d_dp #(
    .INPUT_WORDS  (INPUT_WORDS),
    .WEIGHT_WORDS (WEIGHT_WORDS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .cmd_i          (cmd),
    .take_i         (take),
    .operation_i    (in_i.operation),
    .address_i      (in_i.address),
    .data_i         (in_i.data),
    .out_channel_i  (in_i.out_channel),
    .out_row_i      (in_i.out_row),
    .out_col_i      (in_i.out_col),
    .sts_o          (sts),
    .result_value_o (out_o.result_value),
    .error_o        (out_o.error)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni) take_compute |=> !in_i.ready)
    else $error("compute item taken but input still ready");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && !take_compute |=> in_i.ready)
    else $error("load item stalled the input");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.error |-> out_o.result_value == 32'd0)
    else $error("error result carries a nonzero value");

endmodule
